[sv/atcd_pkg.sv]
// ----------------------------------------------------------------------------
// atcd_pkg: ARMv4T instruction class decoder package
// Class codes and the ARM and Thumb opcode classification functions.
// ----------------------------------------------------------------------------
package atcd_pkg;

    localparam int WORD_W  = 32;
    localparam int CLASS_W = 6;

    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [WORD_W-1:0]  word_t;

    localparam class_t CLS_BX      = 6'd0;
    localparam class_t CLS_B       = 6'd1;
    localparam class_t CLS_BL      = 6'd2;
    localparam class_t CLS_DP0     = 6'd3;
    localparam class_t CLS_MRS     = 6'd19;
    localparam class_t CLS_MSR     = 6'd20;
    localparam class_t CLS_MUL     = 6'd21;
    localparam class_t CLS_MULL    = 6'd22;
    localparam class_t CLS_SDT     = 6'd23;
    localparam class_t CLS_HWT     = 6'd24;
    localparam class_t CLS_BDT     = 6'd25;
    localparam class_t CLS_SWP     = 6'd26;
    localparam class_t CLS_SWI     = 6'd27;
    localparam class_t CLS_UND     = 6'd28;
    localparam class_t CLS_T_FIRST = 6'd29;
    localparam class_t CLS_T_UND   = 6'd48;

    typedef logic [4:0] tfmt_t;
    localparam tfmt_t TFMT_NONE = 5'd0;

    function automatic class_t arm_class(input word_t w);
        logic [11:0] k;
        logic        imm;
        logic        rg;
        logic        test_no_s;
        class_t      c;
        k         = {w[27:20], w[7:4]};
        imm       = (k & 12'he00) == 12'h200;
        rg        = ((k & 12'he00) == 12'h000) && ((k & 12'h009) != 12'h009);
        test_no_s = (k & 12'h190) == 12'h100;
        if (k == 12'h121)
            c = CLS_BX;
        else if ((k & 12'he00) == 12'ha00)
            c = k[8] ? CLS_BL : CLS_B;
        else if (!test_no_s && (imm || rg))
            c = CLS_DP0 + {2'b00, k[8:5]};
        else if ((k & 12'hfbf) == 12'h100)
            c = CLS_MRS;
        else if (((k & 12'hfb0) == 12'h320) || ((k & 12'hfbf) == 12'h120))
            c = CLS_MSR;
        else if ((k & 12'hfcf) == 12'h009)
            c = CLS_MUL;
        else if ((k & 12'hf8f) == 12'h089)
            c = CLS_MULL;
        else if (((k & 12'hc00) == 12'h400) && ((k & 12'he01) != 12'h601))
            c = CLS_SDT;
        else if (((k & 12'he09) == 12'h009) && ((k & 12'he0f) != 12'h009))
            c = CLS_HWT;
        else if ((k & 12'he00) == 12'h800)
            c = CLS_BDT;
        else if ((k & 12'hfbf) == 12'h109)
            c = CLS_SWP;
        else if ((k & 12'hf00) == 12'hf00)
            c = CLS_SWI;
        else
            c = CLS_UND;
        return c;
    endfunction

    function automatic tfmt_t thumb_format(input word_t w);
        logic [9:0] k;
        logic       is_bx;
        logic       bad;
        tfmt_t      f;
        k     = w[15:6];
        is_bx = (k & 10'h00c) == 10'h00c;
        bad   = is_bx ? (k[1] != 1'b0) : (k[1:0] == 2'b00);
        if ((k & 10'h3e0) == 10'h060)      f = 5'd2;
        else if ((k & 10'h380) == 10'h000) f = 5'd1;
        else if ((k & 10'h380) == 10'h080) f = 5'd3;
        else if ((k & 10'h3f0) == 10'h100) f = 5'd4;
        else if ((k & 10'h3f0) == 10'h110) f = bad ? TFMT_NONE : 5'd5;
        else if ((k & 10'h3e0) == 10'h120) f = 5'd6;
        else if ((k & 10'h3c8) == 10'h140) f = 5'd7;
        else if ((k & 10'h3c8) == 10'h148) f = 5'd8;
        else if ((k & 10'h380) == 10'h180) f = 5'd9;
        else if ((k & 10'h3c0) == 10'h200) f = 5'd10;
        else if ((k & 10'h3c0) == 10'h240) f = 5'd11;
        else if ((k & 10'h3c0) == 10'h280) f = 5'd12;
        else if ((k & 10'h3fc) == 10'h2c0) f = 5'd13;
        else if ((k & 10'h3d8) == 10'h2d0) f = 5'd14;
        else if ((k & 10'h3c0) == 10'h300) f = 5'd15;
        else if ((k & 10'h3fc) == 10'h37c) f = 5'd17;
        else if ((k & 10'h3fc) == 10'h378) f = TFMT_NONE;
        else if ((k & 10'h3c0) == 10'h340) f = 5'd16;
        else if ((k & 10'h3e0) == 10'h380) f = 5'd18;
        else if ((k & 10'h3c0) == 10'h3c0) f = 5'd19;
        else                               f = TFMT_NONE;
        return f;
    endfunction

    function automatic class_t thumb_class(input word_t w);
        tfmt_t f;
        f = thumb_format(w);
        return (f == TFMT_NONE) ? CLS_T_UND : (CLS_T_FIRST + {1'b0, f} - 6'd1);
    endfunction

endpackage

[sv/atcd_if.sv]
// ----------------------------------------------------------------------------
// atcd_if: decoder channel interfaces
// Valid/ready channels for fetched words in and decoded items out.
// ----------------------------------------------------------------------------
interface atcd_in_if;
    logic                valid;
    logic                ready;
    logic                in_decode_stage;
    logic                thumb_mode;
    atcd_pkg::word_t     instruction_word;

    modport source (output valid, output in_decode_stage, output thumb_mode,
                    output instruction_word, input ready);
    modport sink   (input valid, input in_decode_stage, input thumb_mode,
                    input instruction_word, output ready);
endinterface

interface atcd_out_if;
    logic                valid;
    logic                ready;
    atcd_pkg::word_t     decoded_word;
    logic                decoded_thumb;
    atcd_pkg::class_t    instr_class;

    modport source (output valid, output decoded_word, output decoded_thumb,
                    output instr_class, input ready);
    modport sink   (input valid, input decoded_word, input decoded_thumb,
                    input instr_class, output ready);
endinterface

[sv/arm_thumb_instruction_class_decoder_top.sv]
// ----------------------------------------------------------------------------
// arm_thumb_instruction_class_decoder_top: ARMv4T instruction class decoder
// Classifies ARM and Thumb words into class numbers, one item per cycle while out_ch is not stalled.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                       | handshake
//  in_ch    | in  | in_decode_stage, thumb_mode, instruction_word | valid/ready
//  out_ch   | out | decoded_word, decoded_thumb, instr_class      | valid/ready
//
//  One item per cycle while out_ch is not stalled; a taken item goes through
//  the input register, then the result register after the class decode,
//  and shows on out_ch from the result register.
//  Items with in_decode_stage clear are taken and give no result.
//  rst_n clears both valid stages at once.
//  A stalled output holds its item; the input register keeps taking items
//  until both stages are full.
// ----------------------------------------------------------------------------
module arm_thumb_instruction_class_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    atcd_in_if.sink     in_ch,
    atcd_out_if.source  out_ch
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_thumb_reg;
    atcd_pkg::word_t    s1_word_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_thumb_reg;
    atcd_pkg::word_t    out_word_reg;
    atcd_pkg::class_t   out_class_reg;

    logic               s2_load;
    logic               s1_load;
    atcd_pkg::class_t   s1_class;

    assign s2_load = !out_valid_reg || out_ch.ready;
    assign s1_load = !s1_valid_reg || s2_load;

    assign s1_class = s1_thumb_reg ? atcd_pkg::thumb_class(s1_word_reg)
                                   : atcd_pkg::arm_class(s1_word_reg);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = in_ch.valid && in_ch.in_decode_stage;
        end
        if (s2_load)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_thumb_reg <= in_ch.thumb_mode;
            s1_word_reg  <= in_ch.instruction_word;
        end
        if (s2_load && s1_valid_reg)
        begin
            out_thumb_reg <= s1_thumb_reg;
            out_word_reg  <= s1_word_reg;
            out_class_reg <= s1_class;
        end
    end

    assign in_ch.ready          = s1_load;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.decoded_word  = out_word_reg;
    assign out_ch.decoded_thumb = out_thumb_reg;
    assign out_ch.instr_class   = out_class_reg;

endmodule

[sv/atcd_checker.sv]
// ----------------------------------------------------------------------------
// atcd_checker: port-level checks for the instruction class decoder
// Class range per state, input ready while the output is empty, and output hold under stall.
// ----------------------------------------------------------------------------
module atcd_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  atcd_pkg::word_t   out_word,
    input  logic              out_thumb,
    input  atcd_pkg::class_t  out_class
);

    a_thumb_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_thumb |->
            (out_class >= atcd_pkg::CLS_T_FIRST) && (out_class <= atcd_pkg::CLS_T_UND))
        else $error("thumb item with class outside thumb range");

    a_arm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_thumb |-> out_class <= atcd_pkg::CLS_UND)
        else $error("arm item with class outside arm range");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_word) && $stable(out_class) && $stable(out_thumb))
        else $error("stalled output item changed");

endmodule

bind arm_thumb_instruction_class_decoder_top atcd_checker u_atcd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.decoded_word),
    .out_thumb (out_ch.decoded_thumb),
    .out_class (out_ch.instr_class)
);

[bench/atcd_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atcd_tb_pkg: instruction class decoder checking package
// Expected-class computation for ARM and Thumb words, and a ledger that
// holds expected decodes in order and compares each decoded item with them.
// ----------------------------------------------------------------------------
package atcd_tb_pkg;

    typedef enum int {
        TF_NONE       = 0,
        TF_MOVE_SHIFT = 1,
        TF_ADD_SUB,
        TF_IMM,
        TF_ALU,
        TF_HIREG,
        TF_PC_LOAD,
        TF_LS_REG,
        TF_LS_SIGN,
        TF_LS_IMM,
        TF_LS_HALF,
        TF_SP_LS,
        TF_LOAD_ADDR,
        TF_SP_ADJ,
        TF_PUSH_POP,
        TF_LS_MULTI,
        TF_COND_BR,
        TF_SWI,
        TF_BRANCH,
        TF_LONG_BL
    } thumb_fmt_t;

    typedef struct {
        atcd_pkg::word_t  word;
        logic             thumb;
        atcd_pkg::class_t cls;
    } decode_t;

    function automatic atcd_pkg::class_t arm_word_class(input atcd_pkg::word_t w);
        logic [2:0] top3;
        logic [3:0] lo;
        logic       test_no_s;
        top3      = w[27:25];
        lo        = w[7:4];
        test_no_s = (w[24:23] == 2'b10) && !w[20];
        if (w[27:20] == 8'h12 && lo == 4'h1)
            return atcd_pkg::CLS_BX;
        if (top3 == 3'b101)
            return w[24] ? atcd_pkg::CLS_BL : atcd_pkg::CLS_B;
        if (!test_no_s && (top3 == 3'b001 || (top3 == 3'b000 && !(w[7] && w[4]))))
            return atcd_pkg::class_t'(atcd_pkg::CLS_DP0 + w[24:21]);
        if (w[27:23] == 5'b00010 && w[21:20] == 2'b00 && lo == 4'h0)
            return atcd_pkg::CLS_MRS;
        if ((w[27:23] == 5'b00110 && w[21:20] == 2'b10) ||
            (w[27:23] == 5'b00010 && w[21:20] == 2'b10 && lo == 4'h0))
            return atcd_pkg::CLS_MSR;
        if (w[27:22] == 6'b000000 && lo == 4'b1001)
            return atcd_pkg::CLS_MUL;
        if (w[27:23] == 5'b00001 && lo == 4'b1001)
            return atcd_pkg::CLS_MULL;
        if (w[27:26] == 2'b01 && !(w[25] && w[4]))
            return atcd_pkg::CLS_SDT;
        if (top3 == 3'b000 && w[7] && w[4] && w[6:5] != 2'b00)
            return atcd_pkg::CLS_HWT;
        if (top3 == 3'b100)
            return atcd_pkg::CLS_BDT;
        if (w[27:23] == 5'b00010 && w[21:20] == 2'b00 && lo == 4'b1001)
            return atcd_pkg::CLS_SWP;
        if (w[27:24] == 4'hf)
            return atcd_pkg::CLS_SWI;
        return atcd_pkg::CLS_UND;
    endfunction

    function automatic atcd_pkg::class_t thumb_word_class(input atcd_pkg::word_t w);
        logic [15:0] h;
        thumb_fmt_t  f;
        h = w[15:0];
        f = TF_NONE;
        if (h[15:11] == 5'b00011)
            f = TF_ADD_SUB;
        else if (h[15:13] == 3'b000)
            f = TF_MOVE_SHIFT;
        else if (h[15:13] == 3'b001)
            f = TF_IMM;
        else if (h[15:10] == 6'b010000)
            f = TF_ALU;
        else if (h[15:10] == 6'b010001)
        begin
            if (h[9:8] == 2'b11)
                f = h[7] ? TF_NONE : TF_HIREG;
            else
                f = (h[7:6] == 2'b00) ? TF_NONE : TF_HIREG;
        end
        else if (h[15:11] == 5'b01001)
            f = TF_PC_LOAD;
        else if (h[15:12] == 4'b0101)
            f = h[9] ? TF_LS_SIGN : TF_LS_REG;
        else if (h[15:13] == 3'b011)
            f = TF_LS_IMM;
        else if (h[15:12] == 4'h8)
            f = TF_LS_HALF;
        else if (h[15:12] == 4'h9)
            f = TF_SP_LS;
        else if (h[15:12] == 4'ha)
            f = TF_LOAD_ADDR;
        else if (h[15:8] == 8'hb0)
            f = TF_SP_ADJ;
        else if (h[15:12] == 4'hb && h[10:9] == 2'b10)
            f = TF_PUSH_POP;
        else if (h[15:12] == 4'hc)
            f = TF_LS_MULTI;
        else if (h[15:8] == 8'hdf)
            f = TF_SWI;
        else if (h[15:8] == 8'hde)
            f = TF_NONE;
        else if (h[15:12] == 4'hd)
            f = TF_COND_BR;
        else if (h[15:11] == 5'b11100)
            f = TF_BRANCH;
        else if (h[15:12] == 4'hf)
            f = TF_LONG_BL;
        if (f == TF_NONE)
            return atcd_pkg::CLS_T_UND;
        return atcd_pkg::class_t'(int'(atcd_pkg::CLS_T_FIRST) + int'(f) - 1);
    endfunction

    class decode_ledger_t;
        decode_t pending_decodes[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_fetch(input logic dec, input logic thm,
                                 input atcd_pkg::word_t w);
            decode_t d;
            if (!dec)
                return;
            d.word  = w;
            d.thumb = thm;
            d.cls   = thm ? thumb_word_class(w) : arm_word_class(w);
            pending_decodes.push_back(d);
        endfunction

        function void check_decode(input atcd_pkg::word_t w, input logic thm,
                                   input atcd_pkg::class_t cls);
            decode_t d;
            if (pending_decodes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected decode: word=%h thumb=%b class=%0d", w, thm, cls);
                return;
            end
            d = pending_decodes.pop_front();
            if (w !== d.word || thm !== d.thumb || cls !== d.cls)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp word=%h thm=%b cls=%0d got word=%h thm=%b cls=%0d",
                             d.word, d.thumb, d.cls, w, thm, cls);
            end
        endfunction

        function int outstanding();
            return pending_decodes.size();
        endfunction
    endclass

endpackage

[bench/tb_arm_thumb_instruction_class_decoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arm_thumb_instruction_class_decoder_top: instruction class decoder bench
// Feeds directed and shaped random ARM and Thumb words with random gaps and
// output stalls, and checks every decoded item against the expected class.
// ----------------------------------------------------------------------------
module tb_arm_thumb_instruction_class_decoder_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DECODE_ITEMS = 1700;

    logic clk;
    logic rst_n;
    logic quiet_phase;
    int   cycle_count = 0;

    atcd_tb_pkg::decode_ledger_t ledger = new();

    atcd_in_if  in_ch();
    atcd_out_if out_ch();

    arm_thumb_instruction_class_decoder_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** arm_thumb_instruction_class_decoder_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            ledger.note_fetch(in_ch.in_decode_stage, in_ch.thumb_mode,
                              in_ch.instruction_word);
        if (rst_n && out_ch.valid && out_ch.ready)
            ledger.check_decode(out_ch.decoded_word, out_ch.decoded_thumb,
                                out_ch.instr_class);
    end

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    task automatic push_fetch(input logic dec, input logic thm, input atcd_pkg::word_t w);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.in_decode_stage  <= dec;
        in_ch.thumb_mode       <= thm;
        in_ch.instruction_word <= w;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain_decodes();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (ledger.outstanding() != 0);
        @(posedge clk);
    endtask

    function automatic atcd_pkg::word_t shape(input atcd_pkg::word_t mask,
                                              input atcd_pkg::word_t value);
        return ($urandom & ~mask) | value;
    endfunction

    function automatic atcd_pkg::word_t shaped_arm_word();
        case ($urandom_range(0, 17))
            0:       return shape(32'h0ff000f0, 32'h01200010);
            1:       return shape(32'h0e000000, 32'h0a000000);
            2:       return shape(32'h0e000000, 32'h02000000);
            3:       return shape(32'h0e000090, 32'h00000000);
            4:       return shape(32'h0e000090, 32'h00000010);
            5:       return shape(32'h0fb000f0, 32'h01000000);
            6:       return shape(32'h0fb000f0, 32'h01200000);
            7:       return shape(32'h0fb00000, 32'h03200000);
            8:       return shape(32'h0fc000f0, 32'h00000090);
            9:       return shape(32'h0f8000f0, 32'h00800090);
            10:      return shape(32'h0c000000, 32'h04000000);
            11:      return shape(32'h0e000090, 32'h00000090);
            12:      return shape(32'h0e000000, 32'h08000000);
            13:      return shape(32'h0fb000f0, 32'h01000090);
            14:      return shape(32'h0f000000, 32'h0f000000);
            15:      return shape(32'h0e000000, 32'h0c000000);
            16:      return shape(32'h0e000010, 32'h06000010);
            default: return $urandom;
        endcase
    endfunction

    function automatic atcd_pkg::word_t shaped_thumb_word();
        case ($urandom_range(0, 21))
            0:       return shape(32'h0000e000, 32'h00000000);
            1:       return shape(32'h0000f800, 32'h00001800);
            2:       return shape(32'h0000e000, 32'h00002000);
            3:       return shape(32'h0000fc00, 32'h00004000);
            4:       return shape(32'h0000fc00, 32'h00004400);
            5:       return shape(32'h0000fc00, 32'h00004400);
            6:       return shape(32'h0000f800, 32'h00004800);
            7:       return shape(32'h0000f000, 32'h00005000);
            8:       return shape(32'h0000e000, 32'h00006000);
            9:       return shape(32'h0000f000, 32'h00008000);
            10:      return shape(32'h0000f000, 32'h00009000);
            11:      return shape(32'h0000f000, 32'h0000a000);
            12:      return shape(32'h0000ff00, 32'h0000b000);
            13:      return shape(32'h0000f600, 32'h0000b400);
            14:      return shape(32'h0000f000, 32'h0000b000);
            15:      return shape(32'h0000f000, 32'h0000c000);
            16:      return shape(32'h0000f000, 32'h0000d000);
            17:      return shape(32'h0000fe00, 32'h0000de00);
            18:      return shape(32'h0000f800, 32'h0000e000);
            19:      return shape(32'h0000f800, 32'h0000e800);
            20:      return shape(32'h0000f000, 32'h0000f000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int   decodes;
        int   sent;
        logic dec;
        logic thm;
        logic paused;
        quiet_phase             = 1'b0;
        rst_n                  <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.in_decode_stage  <= 1'b0;
        in_ch.thumb_mode       <= 1'b0;
        in_ch.instruction_word <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_fetch(1'b1, 1'b0, 32'h00000000);
        push_fetch(1'b1, 1'b0, 32'hffffffff);
        push_fetch(1'b1, 1'b1, 32'h00000000);
        push_fetch(1'b1, 1'b1, 32'hffffffff);
        push_fetch(1'b0, 1'b0, 32'he12fff1e);
        push_fetch(1'b1, 1'b0, 32'he12fff1e);
        push_fetch(1'b1, 1'b0, 32'he1000010);
        push_fetch(1'b1, 1'b0, 32'he10f0000);
        push_fetch(1'b1, 1'b0, 32'he129f000);
        push_fetch(1'b1, 1'b0, 32'he328f0ff);
        push_fetch(1'b1, 1'b0, 32'he0000091);
        push_fetch(1'b1, 1'b0, 32'he0810392);
        push_fetch(1'b1, 1'b0, 32'he1000091);
        push_fetch(1'b1, 1'b0, 32'he1d000b0);
        push_fetch(1'b1, 1'b0, 32'he6000010);
        push_fetch(1'b1, 1'b0, 32'hec000000);
        push_fetch(1'b1, 1'b0, 32'hee000000);
        push_fetch(1'b1, 1'b0, 32'heb000000);
        push_fetch(1'b1, 1'b1, 32'h00004400);
        push_fetch(1'b1, 1'b1, 32'h00004780);
        push_fetch(1'b1, 1'b1, 32'h00004740);
        push_fetch(1'b1, 1'b1, 32'h0000de00);
        push_fetch(1'b1, 1'b1, 32'h0000df00);
        push_fetch(1'b1, 1'b1, 32'h0000e800);
        push_fetch(1'b1, 1'b1, 32'habcd1c00);
        push_fetch(1'b0, 1'b1, 32'h12344400);
        drain_decodes();

        decodes = 0;
        sent    = 0;
        paused  = 1'b0;
        while (decodes < DECODE_ITEMS)
        begin
            if (sent % 150 == 0)
                quiet_phase = ($urandom_range(0, 3) == 0);
            if (!paused && decodes >= DECODE_ITEMS / 2)
            begin
                paused = 1'b1;
                drain_decodes();
            end
            dec = ($urandom_range(0, 9) != 0);
            thm = 1'($urandom_range(0, 1));
            push_fetch(dec, thm, thm ? shaped_thumb_word() : shaped_arm_word());
            sent++;
            if (dec)
                decodes++;
        end

        quiet_phase = 1'b0;
        drain_decodes();
        repeat (4) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("** arm_thumb_instruction_class_decoder_top: PASSED **");
        else
            $display("** arm_thumb_instruction_class_decoder_top: FAILED **");
        $finish;
    end

endmodule
